// ===== hw/rtl/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1he_pkg
// shared types and constants of the sha-1 hash engine: controller states,
// pad byte sources, command and status bundles, round and init constants
// ----------------------------------------------------------------------------
package sha1he_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      load_byte;
    byte_src_t byte_src;
    logic      count_bits;
    logic      latch_len;
    logic      start_comp;
    logic      do_round;
    logic      fold;
    logic      out_shift;
    logic      restart;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
  } dp_stat_t;

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_B1   = 7'd20;
  localparam logic [6:0] ROUND_B2   = 7'd40;
  localparam logic [6:0] ROUND_B3   = 7'd60;

  localparam logic [2:0] OUT_WORD_LAST = 3'd4;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

endpackage

// ===== hw/rtl/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// sha-1 over a byte stream, one byte per request, digest as five words
// ----------------------------------------------------------------------------
// a message byte is taken while idle; the byte that fills a 64-byte block
// starts 80 rounds on one shared round unit, then the chaining add
// the end request adds 9 to 72 pad bytes and one or two compressions, then
// five output words at one per cycle when taken
// synchronous active-low reset loads the initial hash and clears the count
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // has_data
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);

  sha1he_pkg::dp_cmd_t  cmd;
  sha1he_pkg::dp_stat_t stat;

  sha1he_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_has_data (in_tuser),
    .in_end      (in_tlast),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .stat        (stat),
    .cmd         (cmd)
  );

  sha1he_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .stat        (stat),
    .digest_word (out_tdata)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active together");

  a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("request taken while finishing message");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("engine not idle after digest");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tlast)))
    else $error("digest word dropped while stalled");

endmodule

// ===== hw/rtl/sha1he_dp.sv =====
// ----------------------------------------------------------------------------
// sha1he_dp
// datapath: 512-bit message window that doubles as the rolling schedule,
// byte pointer, bit count, length latch, working words and chaining words
// ----------------------------------------------------------------------------
module sha1he_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1he_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output sha1he_pkg::dp_stat_t stat,
  output logic [31:0]          digest_word
);

  logic [511:0]     sched_r, sched_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [63:0]      bit_count_r, bit_count_nxt;
  logic [63:0]      len_r, len_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic [4:0][31:0] work_r, work_nxt;
  logic [4:0][31:0] chain_r, chain_nxt;

  logic [7:0]  byte_val;
  logic [31:0] wt, w_mix, w_new;
  logic [31:0] f_val, k_val, tmp;
  logic [31:0] a, b, c, d, e;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  assign wt    = sched_r[511:480];
  assign w_mix = sched_r[511:480] ^ sched_r[447:416] ^ sched_r[255:224] ^ sched_r[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.byte_src)
      sha1he_pkg::SRC_DATA: byte_val = data_byte;
      sha1he_pkg::SRC_MARK: byte_val = sha1he_pkg::PAD_MARK;
      sha1he_pkg::SRC_LEN:  byte_val = len_r[63:56];
      default:              byte_val = 8'h00;
    endcase
  end

  always_comb begin
    if (rnd_r < sha1he_pkg::ROUND_B1) begin
      f_val = (b & c) | (~b & d);
      k_val = sha1he_pkg::K0;
    end else if (rnd_r < sha1he_pkg::ROUND_B2) begin
      f_val = b ^ c ^ d;
      k_val = sha1he_pkg::K1;
    end else if (rnd_r < sha1he_pkg::ROUND_B3) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = sha1he_pkg::K2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = sha1he_pkg::K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f_val + e + k_val + wt;

  always_comb begin
    sched_nxt     = sched_r;
    pos_nxt       = pos_r;
    bit_count_nxt = bit_count_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    work_nxt      = work_r;
    chain_nxt     = chain_r;
    if (cmd.load_byte) begin
      sched_nxt = {sched_r[503:0], byte_val};
      pos_nxt   = pos_r + 6'd1;
    end
    if (cmd.count_bits) begin
      bit_count_nxt = bit_count_r + 64'd8;
    end
    if (cmd.latch_len) begin
      len_nxt = bit_count_r;
    end else if (cmd.load_byte && cmd.byte_src == sha1he_pkg::SRC_LEN) begin
      len_nxt = {len_r[55:0], 8'h00};
    end
    if (cmd.start_comp) begin
      work_nxt = chain_r;
      rnd_nxt  = 7'd0;
    end
    if (cmd.do_round) begin
      sched_nxt   = {sched_r[479:0], w_new};
      work_nxt[0] = tmp;
      work_nxt[1] = a;
      work_nxt[2] = {b[1:0], b[31:2]};
      work_nxt[3] = c;
      work_nxt[4] = d;
      rnd_nxt     = rnd_r + 7'd1;
    end
    if (cmd.fold) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end
    if (cmd.out_shift) begin
      chain_nxt = {chain_r[0], chain_r[4:1]};
    end
    if (cmd.restart) begin
      chain_nxt     = {sha1he_pkg::H4_INIT, sha1he_pkg::H3_INIT, sha1he_pkg::H2_INIT,
                       sha1he_pkg::H1_INIT, sha1he_pkg::H0_INIT};
      bit_count_nxt = 64'd0;
      pos_nxt       = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 6'd0;
      bit_count_r <= 64'd0;
      chain_r     <= {sha1he_pkg::H4_INIT, sha1he_pkg::H3_INIT, sha1he_pkg::H2_INIT,
                      sha1he_pkg::H1_INIT, sha1he_pkg::H0_INIT};
      rnd_r       <= 7'd0;
    end else begin
      pos_r       <= pos_nxt;
      bit_count_r <= bit_count_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
    len_r   <= len_nxt;
    work_r  <= work_nxt;
  end

  assign stat.pos        = pos_r;
  assign stat.round_last = (rnd_r == sha1he_pkg::ROUND_LAST);
  assign digest_word     = chain_r[0];

endmodule

// ===== hw/rtl/sha1he_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1he_ctrl
// controller: byte intake, padding sequence, round sequencing and digest
// output, driving the datapath through a command bundle
// ----------------------------------------------------------------------------
module sha1he_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_has_data,
  input  logic                 in_end,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_tlast,
  input  sha1he_pkg::dp_stat_t stat,
  output sha1he_pkg::dp_cmd_t  cmd
);

  sha1he_pkg::state_t state_r, state_nxt;
  logic       end_r, end_nxt;
  logic       mark_r, mark_nxt;
  logic       len_act_r, len_act_nxt;
  logic       final_r, final_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1he_pkg::ST_IDLE;
      end_r     <= 1'b0;
      mark_r    <= 1'b0;
      len_act_r <= 1'b0;
      final_r   <= 1'b0;
      cnt_r     <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      end_r     <= end_nxt;
      mark_r    <= mark_nxt;
      len_act_r <= len_act_nxt;
      final_r   <= final_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    end_nxt     = end_r;
    mark_nxt    = mark_r;
    len_act_nxt = len_act_r;
    final_nxt   = final_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.byte_src = sha1he_pkg::SRC_DATA;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    out_tlast   = (cnt_r == sha1he_pkg::OUT_WORD_LAST);
    case (state_r)
      sha1he_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_has_data) begin
            cmd.load_byte  = 1'b1;
            cmd.count_bits = 1'b1;
          end
          if (in_has_data && stat.pos == sha1he_pkg::POS_LAST) begin
            cmd.start_comp = 1'b1;
            end_nxt        = in_end;
            state_nxt      = sha1he_pkg::ST_COMP;
          end else if (in_end) begin
            state_nxt = sha1he_pkg::ST_PAD;
          end
        end
      end
      sha1he_pkg::ST_PAD: begin
        cmd.load_byte = 1'b1;
        if (!mark_r) begin
          cmd.byte_src  = sha1he_pkg::SRC_MARK;
          cmd.latch_len = 1'b1;
          mark_nxt      = 1'b1;
        end else if (len_act_r || stat.pos == sha1he_pkg::POS_LEN) begin
          cmd.byte_src = sha1he_pkg::SRC_LEN;
          len_act_nxt  = 1'b1;
        end else begin
          cmd.byte_src = sha1he_pkg::SRC_ZERO;
        end
        if (stat.pos == sha1he_pkg::POS_LAST) begin
          cmd.start_comp = 1'b1;
          end_nxt        = 1'b1;
          final_nxt      = (cmd.byte_src == sha1he_pkg::SRC_LEN);
          state_nxt      = sha1he_pkg::ST_COMP;
        end
      end
      sha1he_pkg::ST_COMP: begin
        cmd.do_round = 1'b1;
        if (stat.round_last) begin
          state_nxt = sha1he_pkg::ST_FOLD;
        end
      end
      sha1he_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          state_nxt = sha1he_pkg::ST_OUT;
        end else if (end_r) begin
          state_nxt = sha1he_pkg::ST_PAD;
        end else begin
          state_nxt = sha1he_pkg::ST_IDLE;
        end
      end
      sha1he_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.out_shift = 1'b1;
          cnt_nxt       = cnt_r + 3'd1;
          if (cnt_r == sha1he_pkg::OUT_WORD_LAST) begin
            cmd.restart = 1'b1;
            end_nxt     = 1'b0;
            mark_nxt    = 1'b0;
            len_act_nxt = 1'b0;
            final_nxt   = 1'b0;
            cnt_nxt     = 3'd0;
            state_nxt   = sha1he_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha1he_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
